FILE: hw/rtl/lshb_pkg.sv
// ----------------------------------------------------------------------------
// lshb_pkg: shared types and constants for the link session watchdog
// Event codes, session states, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lshb_pkg;

  localparam int TIME_W   = 32;
  localparam int MISSED_W = 8;
  localparam int ACTION_W = 3;
  localparam int CFG_IDX_W = 3;

  // Event codes carried by the action field.
  typedef enum logic [ACTION_W-1:0] {
    ACT_RESET      = 3'd0,
    ACT_CONNECT    = 3'd1,
    ACT_HELLO_ACK  = 3'd2,
    ACT_HEARTBEAT  = 3'd3,
    ACT_DISCONNECT = 3'd4,
    ACT_TICK       = 3'd5
  } action_t;

  // Session state, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_AWAIT = 4'b0010,
    ST_READY = 4'b0100,
    ST_DEAD  = 4'b1000
  } session_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL = 3'd0,
    CFG_MISSED   = 3'd1,
    CFG_BASE     = 3'd2,
    CFG_MAX      = 3'd3
  } cfg_reg_t;

  // Link state codes as shown on the result.
  localparam logic [1:0] LINK_IDLE  = 2'd0;
  localparam logic [1:0] LINK_AWAIT = 2'd1;
  localparam logic [1:0] LINK_READY = 2'd2;
  localparam logic [1:0] LINK_DEAD  = 2'd3;

  // Register values after reset.
  localparam logic [TIME_W-1:0]   RST_INTERVAL = 32'd1000;
  localparam logic [MISSED_W-1:0] RST_MISSED   = 8'd3;
  localparam logic [TIME_W-1:0]   RST_BASE     = 32'd500;
  localparam logic [TIME_W-1:0]   RST_MAX      = 32'd30000;

  function automatic logic [1:0] link_code(session_t s);
    unique case (s)
      ST_IDLE:  link_code = LINK_IDLE;
      ST_AWAIT: link_code = LINK_AWAIT;
      ST_READY: link_code = LINK_READY;
      ST_DEAD:  link_code = LINK_DEAD;
      default:  link_code = LINK_IDLE;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lshb_backoff.sv
// ----------------------------------------------------------------------------
// lshb_backoff: capped exponential backoff delay
// Shifts the base left by the attempt number and clamps to the cap.
// ----------------------------------------------------------------------------
`default_nettype none

module lshb_backoff
  import lshb_pkg::*;
(
  input  logic [TIME_W-1:0] base,
  input  logic [TIME_W-1:0] cap,
  input  logic [TIME_W-1:0] attempt,
  output logic [TIME_W-1:0] delay
);

  localparam int SHIFT_W = $clog2(TIME_W) + 1;
  localparam logic [TIME_W-1:0]  ATTEMPT_CAP = TIME_W'(TIME_W);
  localparam logic [SHIFT_W-1:0] SHIFT_CAP   = SHIFT_W'(TIME_W);

  logic [SHIFT_W-1:0]  shift_amt;
  logic [2*TIME_W-1:0] scaled;

  // Beyond one word width of doublings any nonzero base exceeds the cap,
  // so the shift count saturates there.
  always_comb begin
    shift_amt = (attempt > ATTEMPT_CAP) ? SHIFT_CAP : attempt[SHIFT_W-1:0];
    scaled    = {{TIME_W{1'b0}}, base} << shift_amt;
    delay     = (scaled > {{TIME_W{1'b0}}, cap}) ? cap : scaled[TIME_W-1:0];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/link_session_heartbeat_watchdog.sv
// ----------------------------------------------------------------------------
// link_session_heartbeat_watchdog: link session keeper with heartbeat timing
// Tracks one link session through connect, hello acknowledgement, heartbeats
// and disconnection, and reports a capped exponential backoff delay.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Contents
//   -------  ---------  -------------------  ---------------------------------
//   in       sink       in_valid/in_ready    action, now_time, peer_boot_id,
//                                            attempt_number
//   out      source     out_valid/out_ready  link_state, reconnects,
//                                            hello_accepted, send_heartbeat,
//                                            backoff_delay
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each event waits in the input register and moves to the result register
// once that register can take it; its result is then offered from the result
// register until the receiver takes it.
// Unless the result stalls, one event is accepted per cycle; the session
// registers are updated as an event moves from the input register to the
// result register, so the next event always sees the state left by the previous one.
// A stalled result holds the result register, which in turn holds the input
// register; input ready drops only when both are full.
// Reset is synchronous and restores the registers to their defaults and the
// session to idle; the configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module link_session_heartbeat_watchdog
  import lshb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACTION_W-1:0]  action,
  input  logic [TIME_W-1:0]    now_time,
  input  logic [TIME_W-1:0]    peer_boot_id,
  input  logic [TIME_W-1:0]    attempt_number,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           link_state,
  output logic [TIME_W-1:0]    reconnects,
  output logic                 hello_accepted,
  output logic                 send_heartbeat,
  output logic [TIME_W-1:0]    backoff_delay,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [TIME_W-1:0]   interval;
  logic [MISSED_W-1:0] missed;
  logic [TIME_W-1:0]   base;
  logic [TIME_W-1:0]   cap;

  // The death threshold is a 32 by 8 bit product of two registers, taken
  // straight from them so that it always follows the latest register write.
  logic [TIME_W-1:0]   limit;

  // Input register.
  logic                a_valid;
  logic [ACTION_W-1:0] a_action;
  logic [TIME_W-1:0]   a_now;
  logic [TIME_W-1:0]   a_boot;
  logic [TIME_W-1:0]   a_attempt;

  // Session state.
  session_t            state, state_next;
  logic [TIME_W-1:0]   expected_boot, expected_boot_next;
  logic [TIME_W-1:0]   last_sent, last_sent_next;
  logic [TIME_W-1:0]   last_recv, last_recv_next;
  logic [TIME_W-1:0]   recon_count, recon_count_next;
  logic                hello_next;
  logic                send_next;

  // Result register.
  logic                b_valid;
  logic [1:0]          b_link_state;
  logic [TIME_W-1:0]   b_reconnects;
  logic                b_hello;
  logic                b_send;
  logic [TIME_W-1:0]   b_delay;

  logic                advance;
  logic                step;
  logic [TIME_W-1:0]   silence;
  logic [TIME_W-1:0]   since_sent;
  logic [TIME_W-1:0]   delay;

  assign cfg_ready = 1'b1;

  // The result register can take a new result when it is empty or is being
  // emptied in this cycle; the input register advances whenever it can.
  assign advance  = !b_valid || out_ready;
  assign step     = a_valid && advance;
  assign in_ready = !a_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= RST_INTERVAL;
      missed   <= RST_MISSED;
      base     <= RST_BASE;
      cap      <= RST_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INTERVAL: interval <= cfg_data;
        CFG_MISSED:   missed   <= cfg_data[MISSED_W-1:0];
        CFG_BASE:     base     <= cfg_data;
        CFG_MAX:      cap      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Wrapping product, as wide as a timestamp.
  assign limit = TIME_W'(interval * TIME_W'(missed));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (step) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_action  <= action;
      a_now     <= now_time;
      a_boot    <= peer_boot_id;
      a_attempt <= attempt_number;
    end
  end

  // Elapsed times wrap with the millisecond clock.
  assign silence    = a_now - last_recv;
  assign since_sent = a_now - last_sent;

  always_comb begin
    state_next         = state;
    expected_boot_next = expected_boot;
    last_sent_next     = last_sent;
    last_recv_next     = last_recv;
    recon_count_next   = recon_count;
    hello_next         = 1'b0;
    send_next          = 1'b0;
    unique case (action_t'(a_action))
      ACT_RESET: begin
        state_next         = ST_IDLE;
        expected_boot_next = '0;
        last_sent_next     = '0;
        last_recv_next     = '0;
        recon_count_next   = '0;
      end
      ACT_CONNECT: begin
        state_next         = ST_AWAIT;
        expected_boot_next = a_boot;
        last_sent_next     = a_now;
        last_recv_next     = a_now;
      end
      ACT_HELLO_ACK: begin
        // An acknowledgement carrying the wrong boot id means the peer has
        // restarted underneath us, so the session is abandoned.
        if (state == ST_AWAIT) begin
          if (a_boot != expected_boot) begin
            state_next = ST_DEAD;
          end else begin
            state_next       = ST_READY;
            recon_count_next = '0;
            last_sent_next   = a_now;
            last_recv_next   = a_now;
            hello_next       = 1'b1;
          end
        end
      end
      ACT_HEARTBEAT: begin
        if (state == ST_READY) begin
          last_recv_next = a_now;
        end
      end
      ACT_DISCONNECT: begin
        state_next       = ST_DEAD;
        recon_count_next = recon_count + 1'b1;
      end
      ACT_TICK: begin
        // Silence at or past the threshold wins over a due heartbeat send.
        if (state == ST_READY) begin
          if (silence >= limit) begin
            state_next       = ST_DEAD;
            recon_count_next = recon_count + 1'b1;
          end else if (since_sent >= interval) begin
            last_sent_next = a_now;
            send_next      = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      expected_boot <= '0;
      last_sent     <= '0;
      last_recv     <= '0;
      recon_count   <= '0;
    end else if (step) begin
      state         <= state_next;
      expected_boot <= expected_boot_next;
      last_sent     <= last_sent_next;
      last_recv     <= last_recv_next;
      recon_count   <= recon_count_next;
    end
  end

  lshb_backoff u_backoff (
    .base    (base),
    .cap     (cap),
    .attempt (a_attempt),
    .delay   (delay)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (step) begin
      b_valid <= 1'b1;
    end else if (out_ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      b_link_state <= link_code(state_next);
      b_reconnects <= recon_count_next;
      b_hello      <= hello_next;
      b_send       <= send_next;
      b_delay      <= delay;
    end
  end

  assign out_valid      = b_valid;
  assign link_state     = b_link_state;
  assign reconnects     = b_reconnects;
  assign hello_accepted = b_hello;
  assign send_heartbeat = b_send;
  assign backoff_delay  = b_delay;

endmodule

`default_nettype wire

FILE: hw/rtl/lshb_checker.sv
// ----------------------------------------------------------------------------
// lshb_checker: port-level checks for the link session watchdog
// Watches the result channel for handshake and consistency rules.
// ----------------------------------------------------------------------------
`default_nettype none

module lshb_checker
  import lshb_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        link_state,
  input wire logic [TIME_W-1:0] reconnects,
  input wire logic              hello_accepted,
  input wire logic              send_heartbeat
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its state fields.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(link_state) && $stable(reconnects))
    else $error("result changed while stalled");

  // An accepted hello leaves the session ready with the count cleared.
  a_hello_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && hello_accepted |-> link_state == LINK_READY && reconnects == '0)
    else $error("hello accepted without a fresh ready session");

  // A heartbeat send is only asked for by a tick in a live ready session.
  a_send_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_heartbeat |-> link_state == LINK_READY && !hello_accepted)
    else $error("heartbeat send outside a ready session");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind link_session_heartbeat_watchdog lshb_checker u_lshb_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for link_session_heartbeat_watchdog
// Drives event transactions through the block under several register
// settings, predicts each result with an independent session model and
// compares every result transaction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import lshb_pkg::*;

  // Spare event codes that the block must treat as no-ops.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX   = 3'd7;

  // Attempt numbers from this value on always hit the cap for a nonzero base.
  localparam logic [TIME_W-1:0] SATURATING_ATTEMPT = 32'd32;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [TIME_W-1:0]   now_ms;
    logic [TIME_W-1:0]   boot;
    logic [TIME_W-1:0]   attempt;
  } event_item_t;

  typedef struct {
    logic [1:0]        link;
    logic [TIME_W-1:0] reconnects;
    logic              hello;
    logic              send;
    logic [TIME_W-1:0] delay;
  } session_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [ACTION_W-1:0]  action         = '0;
  logic [TIME_W-1:0]    now_time       = '0;
  logic [TIME_W-1:0]    peer_boot_id   = '0;
  logic [TIME_W-1:0]    attempt_number = '0;

  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [1:0]           link_state;
  logic [TIME_W-1:0]    reconnects;
  logic                 hello_accepted;
  logic                 send_heartbeat;
  logic [TIME_W-1:0]    backoff_delay;

  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [TIME_W-1:0]    cfg_data       = '0;

  link_session_heartbeat_watchdog DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .now_time       (now_time),
    .peer_boot_id   (peer_boot_id),
    .attempt_number (attempt_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .link_state     (link_state),
    .reconnects     (reconnects),
    .hello_accepted (hello_accepted),
    .send_heartbeat (send_heartbeat),
    .backoff_delay  (backoff_delay),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shared bench state.
  // --------------------------------------------------------------------------
  event_item_t     pending_events[$];
  session_result_t expected_results[$];

  int events_queued = 0;   // events handed to the driver so far
  int results_seen  = 0;   // result transactions taken from the block
  int errors        = 0;

  // Percentage chance, per decision, that either side starts an idle burst.
  // Set per phase by the stimulus; zero gives long stretches at full rate.
  int idle_pct = 0;

  // Running millisecond clock used to build plausible event timestamps.
  logic [TIME_W-1:0] clock_ms;

  // --------------------------------------------------------------------------
  // Session model: its own copy of the registers and of the session state.
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0]   m_interval;
  logic [MISSED_W-1:0] m_missed;
  logic [TIME_W-1:0]   m_base;
  logic [TIME_W-1:0]   m_max;

  logic [1:0]          m_link;
  logic [TIME_W-1:0]   m_boot;
  logic [TIME_W-1:0]   m_sent_ms;
  logic [TIME_W-1:0]   m_heard_ms;
  logic [TIME_W-1:0]   m_reconnects;

  function automatic void clear_session_model();
    m_link       = LINK_IDLE;
    m_boot       = '0;
    m_sent_ms    = '0;
    m_heard_ms   = '0;
    m_reconnects = '0;
  endfunction

  // Registers beyond the last index are not decoded; the missed count keeps
  // only its low byte.
  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [TIME_W-1:0] val);
    case (idx)
      CFG_INTERVAL: m_interval = val;
      CFG_MISSED:   m_missed   = val[MISSED_W-1:0];
      CFG_BASE:     m_base     = val;
      CFG_MAX:      m_max      = val;
      default: ;
    endcase
  endfunction

  // Capped exponential backoff. Thirty-two doublings of any nonzero base
  // already exceed every 32-bit cap, so the shift is clamped there.
  function automatic logic [TIME_W-1:0] backoff_for(logic [TIME_W-1:0] attempt);
    logic [63:0] scaled;
    logic [5:0]  shift;
    if (m_base == '0) begin
      return '0;
    end
    shift  = (attempt > SATURATING_ATTEMPT) ? 6'd32 : attempt[5:0];
    scaled = {32'd0, m_base} << shift;
    if (scaled > {32'd0, m_max}) begin
      return m_max;
    end
    return scaled[TIME_W-1:0];
  endfunction

  // Applies one event to the model and returns the result it should produce.
  function automatic session_result_t advance_session(event_item_t ev);
    session_result_t r;
    logic [TIME_W-1:0] death_limit;
    logic [TIME_W-1:0] silence;
    logic [TIME_W-1:0] since_sent;
    r.hello = 1'b0;
    r.send  = 1'b0;
    case (ev.act)
      ACT_RESET: begin
        clear_session_model();
      end
      ACT_CONNECT: begin
        m_link     = LINK_AWAIT;
        m_boot     = ev.boot;
        m_sent_ms  = ev.now_ms;
        m_heard_ms = ev.now_ms;
      end
      ACT_HELLO_ACK: begin
        if (m_link == LINK_AWAIT) begin
          if (ev.boot != m_boot) begin
            m_link = LINK_DEAD;
          end else begin
            m_link       = LINK_READY;
            m_reconnects = '0;
            m_sent_ms    = ev.now_ms;
            m_heard_ms   = ev.now_ms;
            r.hello      = 1'b1;
          end
        end
      end
      ACT_HEARTBEAT: begin
        if (m_link == LINK_READY) begin
          m_heard_ms = ev.now_ms;
        end
      end
      ACT_DISCONNECT: begin
        m_link       = LINK_DEAD;
        m_reconnects = m_reconnects + 32'd1;
      end
      ACT_TICK: begin
        if (m_link == LINK_READY) begin
          // Product and differences all wrap at 32 bits.
          death_limit = m_interval * {24'd0, m_missed};
          silence     = ev.now_ms - m_heard_ms;
          since_sent  = ev.now_ms - m_sent_ms;
          if (silence >= death_limit) begin
            m_link       = LINK_DEAD;
            m_reconnects = m_reconnects + 32'd1;
          end else if (since_sent >= m_interval) begin
            m_sent_ms = ev.now_ms;
            r.send    = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.link       = m_link;
    r.reconnects = m_reconnects;
    r.delay      = backoff_for(ev.attempt);
    return r;
  endfunction

  function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                      logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued events, with random idle bursts between them.
  // A new event is only loaded once the current one has been accepted, so
  // valid and the payload stay put while the block holds off.
  // --------------------------------------------------------------------------
  int          send_gap = 0;
  event_item_t next_ev;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_events.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        // The burst starts with this decision; send_gap holds the rest of it.
        send_gap = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else begin
        next_ev = pending_events.pop_front();
        in_valid       <= 1'b1;
        action         <= next_ev.act;
        now_time       <= next_ev.now_ms;
        peer_boot_id   <= next_ev.boot;
        attempt_number <= next_ev.attempt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: holds off result transactions in random bursts.
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: follows register writes, predicts on every accepted event and
  // checks every accepted result against the oldest prediction. All values
  // are sampled at the rising edge, before the block updates its outputs.
  // --------------------------------------------------------------------------
  event_item_t     seen_ev;
  session_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_interval = RST_INTERVAL;
      m_missed   = RST_MISSED;
      m_base     = RST_BASE;
      m_max      = RST_MAX;
      clear_session_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        seen_ev.act     = action;
        seen_ev.now_ms  = now_time;
        seen_ev.boot    = peer_boot_id;
        seen_ev.attempt = attempt_number;
        expected_results.push_back(advance_session(seen_ev));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected, state %0d",
                   $time, link_state);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("link_state", TIME_W'(want.link), TIME_W'(link_state));
          check_field("reconnects", want.reconnects, reconnects);
          check_field("hello_accepted", TIME_W'(want.hello), TIME_W'(hello_accepted));
          check_field("send_heartbeat", TIME_W'(want.send), TIME_W'(send_heartbeat));
          check_field("backoff_delay", want.delay, backoff_delay);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_event(input logic [ACTION_W-1:0] act,
                            input logic [TIME_W-1:0] now_ms,
                            input logic [TIME_W-1:0] boot,
                            input logic [TIME_W-1:0] attempt);
    event_item_t ev;
    ev.act     = act;
    ev.now_ms  = now_ms;
    ev.boot    = boot;
    ev.attempt = attempt;
    pending_events.push_back(ev);
    events_queued++;
  endtask

  // Waits until every queued event has produced its result. Every event
  // yields exactly one result, so once the counts agree the block is idle;
  // a short pause then covers the result pipeline.
  task automatic settle();
    do @(posedge clk); while (results_seen != events_queued);
    repeat (3) @(posedge clk);
  endtask

  // One register write transaction. Valid is left high so that writes can
  // follow back to back; the caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [TIME_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [TIME_W-1:0] pick_attempt();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 8);
      1:       return $urandom_range(0, 40);
      2:       return $urandom;
      default: return ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom_range(30, 34);
    endcase
  endfunction

  // Time step between events, centred on the heartbeat interval so that
  // sends, quiet ticks and deaths all happen; sometimes an arbitrary jump.
  function automatic logic [TIME_W-1:0] time_step(logic [TIME_W-1:0] iv);
    case ($urandom_range(0, 9))
      0:             return '0;
      1, 2, 3, 4:    return $urandom_range(0, iv >> 1);
      5, 6:          return iv;
      7:             return iv - 32'd1;
      8:             return iv + 32'd1;
      default:       return $urandom;
    endcase
  endfunction

  // Event mix inside an established session: mostly ticks and heartbeats.
  function automatic logic [ACTION_W-1:0] pick_session_action();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return ACT_TICK;
    if (r < 16) return ACT_HEARTBEAT;
    if (r == 16) return ACT_DISCONNECT;
    if (r == 17) return ACT_HELLO_ACK;
    return ACTION_W'($urandom_range(0, 7));
  endfunction

  // Random traffic for one register setting: mostly full sessions (connect,
  // acknowledgement, then heartbeats and ticks), the rest loose events.
  task automatic run_phase(input logic [TIME_W-1:0] iv, input int n);
    int                made;
    int                len;
    logic [TIME_W-1:0] boot;
    logic [TIME_W-1:0] ack_boot;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 7) begin
        boot = $urandom;
        case ($urandom_range(0, 19))
          0:       ack_boot = $urandom;
          1:       ack_boot = boot ^ (32'd1 << $urandom_range(0, 31));
          default: ack_boot = boot;
        endcase
        clock_ms += time_step(iv);
        push_event(ACT_CONNECT, clock_ms, boot, pick_attempt());
        clock_ms += time_step(iv);
        push_event(ACT_HELLO_ACK, clock_ms, ack_boot, pick_attempt());
        len = $urandom_range(2, 14);
        repeat (len) begin
          clock_ms += time_step(iv);
          push_event(pick_session_action(), clock_ms, $urandom, pick_attempt());
        end
        made += len + 2;
      end else begin
        clock_ms += time_step(iv);
        push_event(ACTION_W'($urandom_range(0, 7)), clock_ms, $urandom, pick_attempt());
        made++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0]   ph_interval;
  logic [MISSED_W-1:0] ph_missed;
  logic [TIME_W-1:0]   ph_base;
  logic [TIME_W-1:0]   ph_max;
  logic [TIME_W-1:0]   missed_word;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;

    // Directed events against the register values after reset: interval
    // 1000, three missed beats, base 500 and cap 30000.
    push_event(ACT_TICK,       32'd0,    32'd0, 32'd0);    // tick while idle
    push_event(ACT_HEARTBEAT,  32'd5,    32'd0, 32'd1);    // heartbeat while idle
    push_event(ACT_HELLO_ACK,  32'd10,   32'd0, 32'd5);    // stray acknowledgement
    push_event(ACT_CONNECT,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd6);
    push_event(ACT_HELLO_ACK,  32'd20,   32'd0, 32'd31);   // wrong boot id kills it
    push_event(ACT_DISCONNECT, 32'd30,   32'd0, 32'd32);   // disconnect from dead
    push_event(ACT_CONNECT,    32'd100,  32'h1234_5678, 32'd33);
    push_event(ACT_HEARTBEAT,  32'd150,  32'd0, 32'hFFFF_FFFF);
    push_event(ACT_HELLO_ACK,  32'd200,  32'h1234_5678, 32'd0);
    push_event(ACT_TICK,       32'd700,  32'd0, 32'd2);    // too early to send
    push_event(ACT_TICK,       32'd1200, 32'd0, 32'd3);    // exactly one interval
    push_event(ACT_HEARTBEAT,  32'd2000, 32'd0, 32'd4);
    push_event(ACT_TICK,       32'd2199, 32'd0, 32'd7);    // one short of an interval
    push_event(ACT_TICK,       32'd2200, 32'd0, 32'd8);
    push_event(ACT_SPARE_LO,   32'd2300, 32'hDEAD_BEEF, 32'd9);
    push_event(ACT_SPARE_HI,   32'd2400, 32'hDEAD_BEEF, 32'd10);
    push_event(ACT_TICK,       32'd5000, 32'd0, 32'd11);   // silence at the limit
    push_event(ACT_TICK,       32'd5100, 32'd0, 32'd12);   // tick while dead
    push_event(ACT_HELLO_ACK,  32'd5200, 32'h1234_5678, 32'd13);
    push_event(ACT_CONNECT,    32'hFFFF_FC00, 32'd0, 32'd14);
    push_event(ACT_HELLO_ACK,  32'hFFFF_FC00, 32'd0, 32'd15);
    push_event(ACT_TICK,       32'h0000_03E8, 32'd0, 32'd16); // time wraps past zero
    push_event(ACT_RESET,      32'd0,    32'd0, 32'd17);
    push_event(ACT_DISCONNECT, 32'd0,    32'd0, 32'd18);   // disconnect from idle
    push_event(ACT_RESET,      32'd0,    32'd0, 32'd19);
    settle();

    // Random traffic with the reset register values, then a run of
    // settings that includes the extremes of every register.
    clock_ms = $urandom;
    idle_pct = 0;
    run_phase(RST_INTERVAL, 100);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin  // zero death threshold, zero base
          ph_interval = '0;           ph_missed = '0;
          ph_base     = '0;           ph_max    = 32'hFFFF_FFFF;
        end
        1: begin  // everything at its top value; the product wraps
          ph_interval = 32'hFFFF_FFFF; ph_missed = 8'hFF;
          ph_base     = 32'hFFFF_FFFF; ph_max    = 32'hFFFF_FFFF;
        end
        2: begin  // product wraps to zero; a zero cap forces a zero delay
          ph_interval = 32'h8000_0000; ph_missed = 8'd2;
          ph_base     = 32'd1;         ph_max    = '0;
        end
        3: begin  // the smallest useful timing; the cap is reached at attempt 31
          ph_interval = 32'd1;         ph_missed = 8'd1;
          ph_base     = 32'd1;         ph_max    = 32'h8000_0000;
        end
        4: begin  // full-range missed count
          ph_interval = $urandom_range(1, 2000); ph_missed = MISSED_W'($urandom);
          ph_base     = $urandom_range(0, 1000); ph_max    = $urandom;
        end
        default: begin
          ph_interval = $urandom_range(1, 2000);
          ph_missed   = MISSED_W'($urandom_range(1, 6));
          ph_base     = $urandom_range(0, 1000); ph_max    = $urandom;
        end
      endcase

      // Vary the idling: some phases at full rate, some light, some heavy.
      // The last phase runs with no idling at all.
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 45;
      endcase
      if (p == 7) begin
        idle_pct = 0;
      end

      // A write to an undecoded index must change nothing, and the upper
      // bits of the missed-count word must be dropped.
      missed_word = $urandom;
      missed_word[MISSED_W-1:0] = ph_missed;
      write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)), $urandom);
      write_reg(CFG_INTERVAL, ph_interval);
      write_reg(CFG_MISSED,   missed_word);
      write_reg(CFG_BASE,     ph_base);
      write_reg(CFG_MAX,      ph_max);
      cfg_valid <= 1'b0;

      run_phase(ph_interval, 135);
      settle();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog on the bench itself: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("%0t: run did not complete in time", $time);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
